FILE: design/swpp_pkg.sv
package swpp_pkg;

  parameter int unsigned MAX_PACKET = 64;

  parameter logic [7:0] HDR_BYTE     = 8'hdf;
  parameter int unsigned MIN_LEN     = 19;
  parameter logic [7:0] FUNC_WEIGHT  = 8'h03;
  parameter logic [7:0] CMD_WEIGHT   = 8'h00;
  parameter logic [7:0] MIN_DATA_LEN = 8'd13;
  parameter logic [8:0] LEN_OVERHEAD = 9'd6;

  parameter logic signed [31:0] MIN_WEIGHT_RESET = -32'sd10000;
  parameter logic signed [31:0] MAX_WEIGHT_RESET = 32'sd100000;

  parameter int unsigned PADDR_W = 3;

  typedef enum logic {
    REG_MIN_WEIGHT = 1'b0,
    REG_MAX_WEIGHT = 1'b1
  } swpp_reg_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_HEADER    = 3'd2,
    ST_CHECKSUM  = 3'd3,
    ST_COMMAND   = 3'd4,
    ST_LENGTH    = 3'd5,
    ST_RANGE     = 3'd6
  } swpp_status_e;

endpackage

FILE: design/swpp_byte_if.sv
interface swpp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] packet_byte;
  logic       last_byte;

  modport source (output valid, output packet_byte, output last_byte, input ready);
  modport sink (input valid, input packet_byte, input last_byte, output ready);
endinterface

FILE: design/swpp_result_if.sv
interface swpp_result_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic signed [31:0] weight_tenths;

  modport source (output valid, output status, output weight_tenths, input ready);
  modport sink (input valid, input status, input weight_tenths, output ready);
endinterface

FILE: design/scale_weight_packet_parser_top.sv
// Channel   Direction  Payload                          Handshake
// byte_i    in         packet_byte[7:0], last_byte      valid / ready
// result_o  out        status[2:0], weight_tenths[31:0] valid / ready
// apb       in         min/max weight at 0x0 / 0x4      psel, penable, pwrite, pready
//
// One byte per cycle unless byte_i stalls; a result appears in the cycle after its
// final byte is taken. The result register is the only buffer: byte_i stalls
// only while a result waits in it and result_o.ready is low.
// Reset clears the packet state, the result valid and loads the default range.
module scale_weight_packet_parser_top #(
  parameter int unsigned MaxPacket = swpp_pkg::MAX_PACKET
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  swpp_byte_if.sink                         byte_i,
  swpp_result_if.source                     result_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [swpp_pkg::PADDR_W-1:0]      paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int unsigned IdxW = $clog2(MaxPacket + 1);

  logic signed [31:0] min_weight_q;
  logic signed [31:0] max_weight_q;

  logic [IdxW-1:0] byte_index_q, byte_index_d;
  logic [7:0]      checksum_acc_q, checksum_acc_d;
  logic            header_bad_q, header_bad_d;
  logic [7:0]      func_code_q, func_code_d;
  logic [7:0]      cmd_code_q, cmd_code_d;
  logic [7:0]      payload_len_q, payload_len_d;
  logic [31:0]     raw_weight_q, raw_weight_d;

  logic                  out_valid_q;
  swpp_pkg::swpp_status_e status_q, status_d;
  logic signed [31:0]    weight_q, weight_d;

  logic            accept;
  logic            saturated;
  logic [IdxW-1:0] len;
  logic [8:0]      len_ext;
  logic [8:0]      need_len;
  logic            reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign prdata  = (reg_sel == swpp_pkg::REG_MAX_WEIGHT) ? max_weight_q : min_weight_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_weight_q <= swpp_pkg::MIN_WEIGHT_RESET;
      max_weight_q <= swpp_pkg::MAX_WEIGHT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (reg_sel == swpp_pkg::REG_MAX_WEIGHT) begin
        max_weight_q <= pwdata;
      end else begin
        min_weight_q <= pwdata;
      end
    end
  end

  assign byte_i.ready = !out_valid_q || result_o.ready;
  assign accept       = byte_i.valid && byte_i.ready;

  assign saturated = (byte_index_q == IdxW'(MaxPacket));
  assign len       = saturated ? byte_index_q : byte_index_q + 1'b1;
  assign len_ext   = 9'(len);
  assign need_len  = {1'b0, payload_len_q} + swpp_pkg::LEN_OVERHEAD;

  // Capture header fields, weight and checksum as the packet streams in.
  always_comb begin
    byte_index_d   = byte_index_q;
    checksum_acc_d = checksum_acc_q;
    header_bad_d   = header_bad_q;
    func_code_d    = func_code_q;
    cmd_code_d     = cmd_code_q;
    payload_len_d  = payload_len_q;
    raw_weight_d   = raw_weight_q;
    if (byte_i.last_byte) begin
      byte_index_d   = '0;
      checksum_acc_d = '0;
      header_bad_d   = 1'b0;
      func_code_d    = '0;
      cmd_code_d     = '0;
      payload_len_d  = '0;
      raw_weight_d   = '0;
    end else begin
      if (byte_index_q == IdxW'(0) || byte_index_q == IdxW'(1)) begin
        if (byte_i.packet_byte != swpp_pkg::HDR_BYTE) begin
          header_bad_d = 1'b1;
        end
      end else if (byte_index_q == IdxW'(2)) begin
        func_code_d = byte_i.packet_byte;
      end else if (byte_index_q == IdxW'(3)) begin
        cmd_code_d = byte_i.packet_byte;
      end else if (byte_index_q == IdxW'(4)) begin
        payload_len_d = byte_i.packet_byte;
      end else if (byte_index_q >= IdxW'(5) && byte_index_q <= IdxW'(8)) begin
        raw_weight_d = {raw_weight_q[23:0], byte_i.packet_byte};
      end
      checksum_acc_d = checksum_acc_q + byte_i.packet_byte;
      if (!saturated) begin
        byte_index_d = byte_index_q + 1'b1;
      end
    end
  end

  // Rank the checks; the first failing one wins.
  always_comb begin
    if (len < IdxW'(swpp_pkg::MIN_LEN)) begin
      status_d = swpp_pkg::ST_SHORT;
    end else if (header_bad_q) begin
      status_d = swpp_pkg::ST_HEADER;
    end else if (byte_i.packet_byte != checksum_acc_q) begin
      status_d = swpp_pkg::ST_CHECKSUM;
    end else if (func_code_q != swpp_pkg::FUNC_WEIGHT ||
                 cmd_code_q != swpp_pkg::CMD_WEIGHT) begin
      status_d = swpp_pkg::ST_COMMAND;
    end else if (payload_len_q < swpp_pkg::MIN_DATA_LEN || len_ext < need_len) begin
      status_d = swpp_pkg::ST_LENGTH;
    end else if ($signed(raw_weight_q) < min_weight_q ||
                 $signed(raw_weight_q) > max_weight_q) begin
      status_d = swpp_pkg::ST_RANGE;
    end else begin
      status_d = swpp_pkg::ST_OK;
    end
    if (status_d == swpp_pkg::ST_OK || status_d == swpp_pkg::ST_RANGE) begin
      weight_d = $signed(raw_weight_q);
    end else begin
      weight_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_index_q   <= '0;
      checksum_acc_q <= '0;
      header_bad_q   <= 1'b0;
      func_code_q    <= '0;
      cmd_code_q     <= '0;
      payload_len_q  <= '0;
      raw_weight_q   <= '0;
    end else if (accept) begin
      byte_index_q   <= byte_index_d;
      checksum_acc_q <= checksum_acc_d;
      header_bad_q   <= header_bad_d;
      func_code_q    <= func_code_d;
      cmd_code_q     <= cmd_code_d;
      payload_len_q  <= payload_len_d;
      raw_weight_q   <= raw_weight_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && byte_i.last_byte) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && byte_i.last_byte) begin
      status_q <= status_d;
      weight_q <= weight_d;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.status        = status_q;
  assign result_o.weight_tenths = weight_q;

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import swpp_pkg::*;

  typedef struct packed {
    swpp_status_e       status;
    logic signed [31:0] weight;
  } weight_result_t;

  typedef struct {
    logic [7:0] data;
    logic       fin;
  } stim_byte_t;

  typedef enum int {
    PK_GOOD,
    PK_SHORT,
    PK_HEADER,
    PK_CHECKSUM,
    PK_FUNC,
    PK_CMD,
    PK_DLEN,
    PK_NOISE
  } pkt_kind_e;

  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_PHASES = 8;
  localparam int PHASE_BYTES = 115;

  class weight_packet_predictor;
    int unsigned        byte_cnt;
    logic [7:0]         csum;
    logic               hdr_err;
    logic [7:0]         func;
    logic [7:0]         cmd;
    logic [7:0]         dlen;
    logic [31:0]        weight_raw;
    logic signed [31:0] lo_limit;
    logic signed [31:0] hi_limit;
    weight_result_t     pending_results[$];
    int                 errors;
    int                 results_seen;
    int                 status_hits[7];

    function new();
      clear_packet();
      lo_limit = MIN_WEIGHT_RESET;
      hi_limit = MAX_WEIGHT_RESET;
      errors = 0;
      results_seen = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
    endfunction

    function void clear_packet();
      byte_cnt = 0;
      csum = 8'h00;
      hdr_err = 1'b0;
      func = 8'h00;
      cmd = 8'h00;
      dlen = 8'h00;
      weight_raw = 32'h0;
    endfunction

    function void take_byte(logic [7:0] b, logic fin);
      int                 plen;
      logic signed [31:0] w;
      weight_result_t     r;
      if (!fin) begin
        if (byte_cnt < 2) begin
          if (b != HDR_BYTE) hdr_err = 1'b1;
        end else if (byte_cnt == 2) func = b;
        else if (byte_cnt == 3) cmd = b;
        else if (byte_cnt == 4) dlen = b;
        else if (byte_cnt <= 8) weight_raw = {weight_raw[23:0], b};
        csum = csum + b;
        if (byte_cnt < MAX_PACKET) byte_cnt++;
        return;
      end
      plen = (byte_cnt + 1 > MAX_PACKET) ? int'(MAX_PACKET) : int'(byte_cnt + 1);
      w = $signed(weight_raw);
      if (plen < int'(MIN_LEN)) r.status = ST_SHORT;
      else if (hdr_err) r.status = ST_HEADER;
      else if (b != csum) r.status = ST_CHECKSUM;
      else if (func != FUNC_WEIGHT || cmd != CMD_WEIGHT) r.status = ST_COMMAND;
      else if (dlen < MIN_DATA_LEN || plen < int'(LEN_OVERHEAD) + int'(dlen))
        r.status = ST_LENGTH;
      else if (w < lo_limit || w > hi_limit) r.status = ST_RANGE;
      else r.status = ST_OK;
      r.weight = (r.status == ST_OK || r.status == ST_RANGE) ? w : 32'sd0;
      pending_results.push_back(r);
      clear_packet();
    endfunction

    function void match_result(logic [2:0] st, logic signed [31:0] w);
      weight_result_t exp_r;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: status %0d weight %0d", st, w);
        return;
      end
      exp_r = pending_results.pop_front();
      results_seen++;
      status_hits[int'(exp_r.status)]++;
      if (st != exp_r.status || w != exp_r.weight) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected status %0d weight %0d, got status %0d weight %0d",
                   exp_r.status, exp_r.weight, st, w);
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  swpp_byte_if   byte_if ();
  swpp_result_if result_if ();

  weight_packet_predictor sb = new();
  stim_byte_t             stim_q[$];
  int                     bytes_sent = 0;
  int                     cycle_count = 0;
  int                     rx_cycle = 0;
  int                     rx_mode = 0;

  scale_weight_packet_parser_top uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (byte_if),
    .result_o (result_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    rx_cycle++;
    if (rx_cycle % 256 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0: result_if.ready <= 1'b1;
      1: result_if.ready <= ($urandom_range(0, 3) != 0);
      2: result_if.ready <= (rx_cycle % 8 == 0);
      default: result_if.ready <= ((rx_cycle % 32) > 24);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_if.valid && result_if.ready)
      sb.match_result(result_if.status, result_if.weight_tenths);
  end

  function automatic void push_stim(logic [7:0] b, logic fin);
    stim_byte_t s;
    s.data = b;
    s.fin = fin;
    stim_q.push_back(s);
  endfunction

  function automatic logic [31:0] pick_weight();
    longint             span;
    longint unsigned    r;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    lo = sb.lo_limit;
    hi = sb.hi_limit;
    r = {$urandom, $urandom};
    span = longint'(hi) - longint'(lo) + 1;
    case ($urandom_range(0, 5))
      0: return $urandom;
      1, 2: begin
        if (span > 0) return 32'(longint'(lo) + longint'(r % $unsigned(span)));
        return $urandom;
      end
      3: return 32'(longint'(lo) + $urandom_range(0, 2) - 1);
      4: return 32'(longint'(hi) + $urandom_range(0, 2) - 1);
      default: return {($urandom_range(0, 1) != 0) ? 8'hff : 8'h00, 24'($urandom)};
    endcase
  endfunction

  function automatic void add_packet(pkt_kind_e kind, logic [31:0] w);
    logic [7:0] body[$];
    logic [7:0] sum;
    int         dlen;
    int         total;
    int         keep;
    int         plen;
    if (kind == PK_NOISE) begin
      repeat ($urandom_range(0, 29)) push_stim(8'($urandom), 1'b0);
      push_stim(8'($urandom), 1'b1);
      return;
    end
    dlen = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 58) : $urandom_range(13, 16);
    total = int'(LEN_OVERHEAD) + dlen + $urandom_range(0, 3);
    if ($urandom_range(0, 9) == 0) total = $urandom_range(65, 90);
    body.push_back(HDR_BYTE);
    body.push_back(HDR_BYTE);
    body.push_back(FUNC_WEIGHT);
    body.push_back(CMD_WEIGHT);
    body.push_back(8'(dlen));
    for (int i = 0; i < 4; i++) body.push_back(w[31-8*i -: 8]);
    while (body.size() < total - 1) body.push_back(8'($urandom));
    case (kind)
      PK_SHORT: begin
        keep = $urandom_range(0, 17);
        while (body.size() > keep) void'(body.pop_back());
      end
      PK_HEADER: body[$urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
      PK_FUNC: body[2] ^= 8'($urandom_range(1, 255));
      PK_CMD: body[3] ^= 8'($urandom_range(1, 255));
      PK_DLEN: begin
        plen = (total > int'(MAX_PACKET)) ? int'(MAX_PACKET) : total;
        if ($urandom_range(0, 1) != 0) body[4] = 8'($urandom_range(0, 12));
        else body[4] = 8'(plen - int'(LEN_OVERHEAD) + $urandom_range(1, 20));
      end
      default: ;
    endcase
    sum = 8'h00;
    foreach (body[i]) sum += body[i];
    if (kind == PK_CHECKSUM) sum ^= 8'($urandom_range(1, 255));
    foreach (body[i]) push_stim(body[i], 1'b0);
    push_stim(sum, 1'b1);
  endfunction

  function automatic pkt_kind_e pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return PK_GOOD;
    if (r < 61) return PK_SHORT;
    if (r < 67) return PK_HEADER;
    if (r < 73) return PK_CHECKSUM;
    if (r < 79) return PK_FUNC;
    if (r < 85) return PK_CMD;
    if (r < 92) return PK_DLEN;
    return PK_NOISE;
  endfunction

  task automatic apb_write(swpp_reg_e r, logic [31:0] v);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(4 * int'(r));
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (r == REG_MIN_WEIGHT) sb.lo_limit = v;
    else sb.hi_limit = v;
  endtask

  task automatic wait_idle();
    while (sb.pending_results.size() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic drive_bytes();
    int   idx;
    int   run_left;
    int   gap_left;
    logic accepted;
    idx = 0;
    run_left = $urandom_range(1, 40);
    gap_left = 0;
    while (idx < stim_q.size()) begin
      @(posedge clk_i);
      accepted = byte_if.valid && byte_if.ready;
      if (accepted) begin
        sb.take_byte(stim_q[idx].data, stim_q[idx].fin);
        bytes_sent++;
        idx++;
      end
      if (accepted || !byte_if.valid) begin
        if (gap_left > 0) begin
          byte_if.valid <= 1'b0;
          gap_left--;
        end else if (idx < stim_q.size()) begin
          byte_if.valid <= 1'b1;
          byte_if.packet_byte <= stim_q[idx].data;
          byte_if.last_byte <= stim_q[idx].fin;
          run_left--;
          if (run_left == 0) begin
            run_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          byte_if.valid <= 1'b0;
        end
      end
    end
  endtask

  initial begin
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic signed [31:0] t;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = 32'h0;
    byte_if.valid = 1'b0;
    byte_if.packet_byte = 8'h00;
    byte_if.last_byte = 1'b0;
    result_if.ready = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_stim(8'hff, 1'b1);
    add_packet(PK_GOOD, MAX_WEIGHT_RESET);
    for (int i = 0; i < 3; i++) push_stim(8'h00, 1'b0);
    push_stim(8'h00, 1'b1);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase > 0) begin
        wait_idle();
        case (phase)
          1: begin lo = 32'sh8000_0000; hi = 32'sh7fff_ffff; end
          2: begin lo = $urandom; hi = lo; end
          3: begin lo = 32'sd5000; hi = -32'sd5000; end
          4: begin lo = 32'sd0; hi = 32'sd0; end
          5: begin lo = 32'sh7fff_ffff; hi = 32'sh8000_0000; end
          6: begin
            lo = $urandom;
            hi = $urandom;
            if (lo > hi) begin
              t = lo;
              lo = hi;
              hi = t;
            end
          end
          default: begin lo = MIN_WEIGHT_RESET; hi = MAX_WEIGHT_RESET; end
        endcase
        if ($urandom_range(0, 1) != 0) begin
          apb_write(REG_MIN_WEIGHT, lo);
          apb_write(REG_MAX_WEIGHT, hi);
        end else begin
          apb_write(REG_MAX_WEIGHT, hi);
          apb_write(REG_MIN_WEIGHT, lo);
        end
      end
      while (stim_q.size() < PHASE_BYTES) add_packet(pick_kind(), pick_weight());
      drive_bytes();
      stim_q.delete();
    end

    while (sb.pending_results.size() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    sb.errors += sb.pending_results.size();
    $display("Covered %0d bytes, %0d results, %0d weight range settings, %0d errors",
             bytes_sent, sb.results_seen, NUM_PHASES, sb.errors);
    $display("Result mix: ok %0d short %0d header %0d checksum %0d command %0d length %0d range %0d",
             sb.status_hits[0], sb.status_hits[1], sb.status_hits[2], sb.status_hits[3],
             sb.status_hits[4], sb.status_hits[5], sb.status_hits[6]);
    if (sb.errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: scale_weight_packet_parser_top.f
design/swpp_pkg.sv
design/swpp_byte_if.sv
design/swpp_result_if.sv
design/scale_weight_packet_parser_top.sv
tb/tb.sv
